// ===== rtl/core/pdab_pkg.sv =====
// Shared types, widths and constants for the deadband PID controller.
`default_nettype none
package pdab_pkg;

  localparam int GainW  = 16;
  localparam int PosW   = 16;
  localparam int ErrW   = PosW + 1;
  localparam int ProdW  = GainW + ErrW;
  localparam int AccW   = 40;
  localparam int SumW   = AccW + 1;
  localparam int ResW   = ProdW + 2;
  localparam int DriveW = 16;
  localparam int DzW    = 12;
  localparam int ThrW   = DzW + 1;
  localparam int CntW   = 2;
  localparam int CfgIdxW = 2;

  // Q.8 constants: 100 is 25600 and 2 is 512.
  localparam int Q8Hundred = 25600;
  localparam int Q8Two     = 512;
  localparam int ErrLimit  = 100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INTEG_GAIN = 2'd1,
    CFG_DERIV_GAIN = 2'd2,
    CFG_DEAD_ZONE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GainW-1:0] prop_gain;
    logic signed [GainW-1:0] integ_gain;
    logic signed [GainW-1:0] deriv_gain;
    logic [DzW-1:0]          dead_zone;
  } cfg_t;

  // One item after the multiplier stage.
  typedef struct packed {
    logic                     preset;
    logic signed [ErrW-1:0]   err;
    logic signed [ProdW-1:0]  p_term;
    logic signed [ProdW-1:0]  i_step;
    logic signed [ProdW-1:0]  d_term;
    logic signed [DriveW-1:0] integ_preset;
  } stage_t;

endpackage
`default_nettype wire

// ===== rtl/core/pdab_front.sv =====
// Input register, error and gain products, and the product stage register.
`default_nettype none
module pdab_front import pdab_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_op,
  input  wire logic signed [PosW-1:0]  in_measured,
  input  wire logic signed [PosW-1:0]  in_target,
  input  wire logic signed [DriveW-1:0] in_integ_preset,
  input  wire logic                    s1_take,
  output logic                         s1_valid,
  output stage_t                       s1_data
);

  logic                     s0_v_r, s0_v_nxt;
  logic                     s0_op_r;
  logic signed [PosW-1:0]   s0_meas_r;
  logic signed [PosW-1:0]   s0_tgt_r;
  logic signed [DriveW-1:0] s0_pre_r;
  logic signed [PosW-1:0]   prev_pos_r, prev_pos_nxt;
  logic                     s1_v_r, s1_v_nxt;
  stage_t                   s1_r, s1_nxt;

  logic                     s0_fire;
  logic                     in_take;
  logic signed [ErrW-1:0]   err;
  logic signed [ErrW-1:0]   dpos;
  logic signed [ProdW-1:0]  err_x, dpos_x, pg_x, ig_x, dg_x;

  assign s0_fire  = s0_v_r && (!s1_v_r || s1_take);
  assign in_stall = s0_v_r && !s0_fire;
  assign in_take  = in_valid && !in_stall;

  assign err  = ErrW'(s0_tgt_r) - ErrW'(s0_meas_r);
  assign dpos = ErrW'(s0_meas_r) - ErrW'(prev_pos_r);

  assign err_x  = ProdW'(err);
  assign dpos_x = ProdW'(dpos);
  assign pg_x   = ProdW'(cfg.prop_gain);
  assign ig_x   = ProdW'(cfg.integ_gain);
  assign dg_x   = ProdW'(cfg.deriv_gain);

  always_comb begin
    s1_nxt.preset       = s0_op_r;
    s1_nxt.err          = err;
    s1_nxt.p_term       = pg_x * err_x;
    s1_nxt.i_step       = ig_x * err_x;
    s1_nxt.d_term       = dg_x * dpos_x;
    s1_nxt.integ_preset = s0_pre_r;
  end

  always_comb begin
    s0_v_nxt = s0_v_r;
    if (in_take) begin
      s0_v_nxt = 1'b1;
    end else if (s0_fire) begin
      s0_v_nxt = 1'b0;
    end
    s1_v_nxt = s1_v_r;
    if (s0_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_take) begin
      s1_v_nxt = 1'b0;
    end
    // A preset leaves the remembered position alone.
    prev_pos_nxt = prev_pos_r;
    if (s0_fire && !s0_op_r) begin
      prev_pos_nxt = s0_meas_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r     <= 1'b0;
      s1_v_r     <= 1'b0;
      prev_pos_r <= '0;
    end else begin
      s0_v_r     <= s0_v_nxt;
      s1_v_r     <= s1_v_nxt;
      prev_pos_r <= prev_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_op_r   <= in_op;
      s0_meas_r <= in_measured;
      s0_tgt_r  <= in_target;
      s0_pre_r  <= in_integ_preset;
    end
    if (s0_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = s1_r;

endmodule
`default_nettype wire

// ===== rtl/core/pdab_back.sv =====
// Integrator, deadband and anti-bounce state, output shaping and result register.
`default_nettype none
module pdab_back import pdab_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     cfg_clear,
  input  wire logic                     s1_valid,
  input  wire stage_t                   s1_data,
  output logic                          s1_take,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DriveW-1:0]      out_drive
);

  localparam logic signed [ProdW-1:0] PHi  = ProdW'(Q8Hundred);
  localparam logic signed [ProdW-1:0] PLo  = -ProdW'(Q8Hundred);
  localparam logic signed [SumW-1:0]  SHi  = SumW'(Q8Hundred);
  localparam logic signed [SumW-1:0]  SLo  = -SumW'(Q8Hundred);
  localparam logic signed [ResW-1:0]  RHi  = ResW'(Q8Hundred);
  localparam logic signed [ResW-1:0]  RLo  = -ResW'(Q8Hundred);
  localparam logic signed [ResW-1:0]  RTwo = ResW'(Q8Two);
  localparam logic signed [ResW-1:0]  RNTwo = -ResW'(Q8Two);
  localparam logic signed [ErrW-1:0]  EHi  = ErrW'(ErrLimit);
  localparam logic signed [ErrW-1:0]  ELo  = -ErrW'(ErrLimit);
  localparam logic [CntW-1:0]         CntTop = CntW'(3);

  logic signed [AccW-1:0]   acc_r, acc_nxt;
  logic [CntW-1:0]          bc_r, bc_nxt;
  logic [CntW-1:0]          sw_r, sw_nxt;
  logic                     pwz_r, pwz_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DriveW-1:0] out_drive_r, out_drive_nxt;

  logic                     large_err, outside, p_large, restart, nz;
  logic [ErrW-1:0]          aerr;
  logic [ThrW-1:0]          thr;
  logic [CntW-1:0]          bc0, sw0, bc1, bc2, sw1, sw2;
  logic signed [SumW-1:0]   acc_sum;
  logic signed [DriveW-1:0] acc_cl, acc1;
  logic signed [ResW-1:0]   res, res_adj;
  logic signed [AccW-1:0]   i_x, boost, acc_new;
  logic signed [DriveW-1:0] drive;

  assign s1_take = s1_valid && (s1_data.preset || !out_valid_r || !out_stall);

  always_comb begin
    large_err = (s1_data.err > EHi) || (s1_data.err < ELo);
    aerr      = s1_data.err[ErrW-1] ? (~s1_data.err + 1'b1) : s1_data.err;
    bc0       = large_err ? '0 : bc_r;
    sw0       = large_err ? '0 : sw_r;
    thr       = {1'b0, cfg.dead_zone} + ThrW'(sw0);
    outside   = aerr > ErrW'(thr);
    p_large   = (s1_data.p_term >= PHi) || (s1_data.p_term <= PLo);

    acc_sum = SumW'(acc_r) + SumW'(s1_data.i_step);
    if (acc_sum > SHi) begin
      acc_cl = DriveW'(Q8Hundred);
    end else if (acc_sum < SLo) begin
      acc_cl = -DriveW'(Q8Hundred);
    end else begin
      acc_cl = acc_sum[DriveW-1:0];
    end
    acc1 = (outside && !p_large) ? acc_cl : '0;

    if (outside) begin
      res = ResW'(s1_data.p_term) + ResW'(acc1) + ResW'(s1_data.d_term);
    end else begin
      res = '0;
    end

    // Small nonzero outputs are pushed out to a magnitude of two.
    res_adj = res;
    if (res > 0 && res < RTwo) begin
      res_adj = RTwo;
    end else if (res < 0 && res > RNTwo) begin
      res_adj = RNTwo;
    end
    nz      = res != '0;
    restart = nz && pwz_r;

    // The restart boost is fifty times the I step: 32 + 16 + 2.
    i_x     = AccW'(s1_data.i_step);
    boost   = (i_x <<< 5) + (i_x <<< 4) + (i_x <<< 1);
    acc_new = AccW'(acc1) + (restart ? boost : '0);

    bc1 = restart ? bc0 + 1'b1 : bc0;
    if (bc1 == CntTop) begin
      bc2 = '0;
      sw1 = sw0 + 1'b1;
    end else begin
      bc2 = bc1;
      sw1 = sw0;
    end
    sw2 = (sw1 == CntTop) ? '0 : sw1;

    if (res_adj > RHi) begin
      drive = DriveW'(Q8Hundred);
    end else if (res_adj < RLo) begin
      drive = -DriveW'(Q8Hundred);
    end else begin
      drive = res_adj[DriveW-1:0];
    end
  end

  always_comb begin
    acc_nxt       = acc_r;
    bc_nxt        = bc_r;
    sw_nxt        = sw_r;
    pwz_nxt       = pwz_r;
    out_drive_nxt = out_drive_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cfg_clear) begin
      acc_nxt = '0;
    end else if (s1_take) begin
      if (s1_data.preset) begin
        acc_nxt = AccW'(s1_data.integ_preset);
      end else begin
        acc_nxt       = acc_new;
        bc_nxt        = bc2;
        sw_nxt        = sw2;
        pwz_nxt       = !nz;
        out_drive_nxt = drive;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      bc_r        <= '0;
      sw_r        <= '0;
      pwz_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      bc_r        <= bc_nxt;
      sw_r        <= sw_nxt;
      pwz_r       <= pwz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_drive_r <= out_drive_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

endmodule
`default_nettype wire

// ===== rtl/core/pid_deadband_antibounce.sv =====
// Top level of the deadband PID position controller with anti-bounce.
// Takes one item per clock cycle when the result side keeps up. A control step
// passes the input register, the product register and the result register in
// that order; a preset gives no result. The rate is set by the integrator
// update, which closes its state loop. The three gain multipliers sit in
// their own stage ahead of it. Configuration writes are always ready, take
// effect at once and clear the integral; write them only while no item is in
// flight. A result waiting in the output register does not stop new items
// from filling the first two stages.
`default_nettype none
module pid_deadband_antibounce import pdab_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_op,
  input  wire logic signed [PosW-1:0]    in_measured,
  input  wire logic signed [PosW-1:0]    in_target,
  input  wire logic signed [DriveW-1:0]  in_integ_preset,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [DriveW-1:0]       out_drive,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CfgIdxW-1:0]        cfg_index,
  input  wire logic [GainW-1:0]          cfg_data
);

  cfg_t   cfg_r, cfg_nxt;
  logic   cfg_we;
  logic   cfg_clear;
  logic   s1_take;
  logic   s1_valid;
  stage_t s1_data;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_we) begin
      cfg_clear = 1'b1;
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:  cfg_nxt.prop_gain  = cfg_data;
        CFG_INTEG_GAIN: cfg_nxt.integ_gain = cfg_data;
        CFG_DERIV_GAIN: cfg_nxt.deriv_gain = cfg_data;
        CFG_DEAD_ZONE:  cfg_nxt.dead_zone  = cfg_data[DzW-1:0];
        default:        cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pdab_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_measured     (in_measured),
    .in_target       (in_target),
    .in_integ_preset (in_integ_preset),
    .s1_take         (s1_take),
    .s1_valid        (s1_valid),
    .s1_data         (s1_data)
  );

  pdab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_clear (cfg_clear),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_drive (out_drive)
  );

endmodule
`default_nettype wire
